// ===== rtl/svd_pkg.sv =====
`timescale 1ns / 1ps

package svd_pkg;

    // Volume limits
    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 4096;

    // One plane of match bits per window memory
    localparam int PLANE_DEPTH = MAX_X * MAX_Y;
    localparam int ADDR_W      = $clog2(PLANE_DEPTH);
    localparam int SLICE_W     = $clog2(PLANE_DEPTH + 1);

    // Field and register widths
    localparam int LABEL_W    = 16;
    localparam int DIM_X_W    = 9;
    localparam int DIM_Y_W    = 9;
    localparam int DIM_Z_W    = 13;
    localparam int POS_X_W    = 8;
    localparam int POS_Y_W    = 8;
    localparam int POS_Z_W    = 12;
    localparam int COUNT_W    = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [DIM_X_W-1:0] DIM_X_RST    = DIM_X_W'(256);
    localparam logic [DIM_Y_W-1:0] DIM_Y_RST    = DIM_Y_W'(256);
    localparam logic [DIM_Z_W-1:0] DIM_Z_RST    = DIM_Z_W'(4096);
    localparam logic [LABEL_W-1:0] FG_LABEL_RST = LABEL_W'(1);

    // Result queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_X    = 2'd0,
        REG_DIM_Y    = 2'd1,
        REG_DIM_Z    = 2'd2,
        REG_FG_LABEL = 2'd3
    } cfg_reg_t;

    // Request from the control stage to the window stage
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ADDR_W-1:0]  rd_next;
        logic [ADDR_W-1:0]  rd_up;
        logic [ADDR_W-1:0]  rd_down;
        logic               match;
        logic               has_result;
        logic               border;
        logic               one_slice;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic [POS_Z_W-1:0] pos_z;
        logic               last;
    } svd_req_t;

    typedef struct packed {
        logic               last;
        logic               surface;
        logic               foreground;
        logic [POS_Z_W-1:0] pos_z;
        logic [POS_Y_W-1:0] pos_y;
        logic [POS_X_W-1:0] pos_x;
    } svd_result_t;

endpackage

// ===== rtl/surface_voxel_detector_3d.sv =====
`timescale 1ns / 1ps
// Channel   Ports              Contents
// --------  -----------------  -------------------------------------------------
// s_        tvalid tready      tdata[15:0] voxel_label, tuser[0] flush
// m_        tvalid tready      tdata pos_x/pos_y/pos_z, tuser fg/surface, tlast
// cfg_      we index data      0 dim_x, 1 dim_y, 2 dim_z, 3 foreground_label
//
// One request per cycle while s_tready is high; a voxel's result is registered and
// queued after the request one plane (dim_x*dim_y requests) later that judges it.
// The rate is set by the two plane memories: each takes one write and two reads
// per request, and their reads are registered.
// Reset (aresetn low, synchronous) clears counters, the result queue and the
// registers to their defaults; the plane memories are not cleared.
// A three-entry result queue decouples the sides: s_tready drops only while the
// queue plus the result in flight would fill it.
module surface_voxel_detector_3d (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] voxel_label
    input  logic [0:0]                        s_tuser,   // [0] flush
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [7:0] pos_x, [15:8] pos_y,
                                                         // [27:16] pos_z, [31:28] zero
    output logic [1:0]                        m_tuser,   // [0] is_foreground,
                                                         // [1] is_surface
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [svd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    svd_pkg::svd_req_t                  req;
    svd_pkg::svd_result_t               win_res, out_res;
    logic                               win_valid, s_acc;
    logic [svd_pkg::FIFO_CNT_W-1:0]     level;
    logic [svd_pkg::FIFO_CNT_W:0]       committed;

    // Hold off new requests while queued plus in-flight results could fill the queue
    assign committed = {1'b0, level} + (svd_pkg::FIFO_CNT_W + 1)'(win_valid);
    assign s_tready  = committed < (svd_pkg::FIFO_CNT_W + 1)'(svd_pkg::FIFO_DEPTH);
    assign s_acc     = s_tvalid && s_tready;

    // Stage 0: counters, coordinates and memory addresses
    svd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_acc    (s_acc),
        .in_label  (s_tdata[svd_pkg::LABEL_W-1:0]),
        .in_flush  (s_tuser[0]),
        .req       (req)
    );

    // Stage 1: plane memories and the neighbor test
    svd_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .res_valid (win_valid),
        .res       (win_res)
    );

    // Result queue in front of the master side
    svd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (win_valid),
        .push_data (win_res),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .level     (level)
    );

    assign m_tdata = {4'b0000, out_res.pos_z, out_res.pos_y, out_res.pos_x};
    assign m_tuser = {out_res.surface, out_res.foreground};
    assign m_tlast = out_res.last;

endmodule

// ===== rtl/svd_ctrl.sv =====
`timescale 1ns / 1ps

module svd_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [svd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_acc,
    input  logic [svd_pkg::LABEL_W-1:0]       in_label,
    input  logic                              in_flush,
    output svd_pkg::svd_req_t                 req
);

    logic [svd_pkg::DIM_X_W-1:0]  dim_x_reg;
    logic [svd_pkg::DIM_Y_W-1:0]  dim_y_reg;
    logic [svd_pkg::DIM_Z_W-1:0]  dim_z_reg;
    logic [svd_pkg::LABEL_W-1:0]  fg_label_reg;
    logic [svd_pkg::SLICE_W-1:0]  slice_reg;
    logic [svd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [svd_pkg::ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [svd_pkg::POS_X_W-1:0]  out_x_reg, out_x_next;
    logic [svd_pkg::POS_Y_W-1:0]  out_y_reg, out_y_next;
    logic [svd_pkg::POS_Z_W-1:0]  out_z_reg, out_z_next;

    logic [svd_pkg::DIM_X_W-1:0]  nx, nx_m1;
    logic [svd_pkg::DIM_Y_W-1:0]  ny, ny_m1;
    logic [svd_pkg::DIM_Z_W-1:0]  nz, nz_m1;
    logic [svd_pkg::DIM_X_W+svd_pkg::DIM_Y_W-1:0] slice_prod;

    logic [svd_pkg::ADDR_W-1:0]   p_eff;
    logic [svd_pkg::SLICE_W-1:0]  p_inc, up_sum, up_wrap, dn_diff, dn_wrap;
    logic                         has_res, last, border, match;
    logic [svd_pkg::DIM_X_W-1:0]  x_inc;
    logic [svd_pkg::DIM_Y_W-1:0]  y_inc;
    logic [svd_pkg::DIM_Z_W-1:0]  z_inc;

    // Clamp dimensions: zero acts as one, above the maximum acts as the maximum
    assign nx = (dim_x_reg == '0) ? svd_pkg::DIM_X_W'(1) :
                (dim_x_reg > svd_pkg::DIM_X_W'(svd_pkg::MAX_X)) ?
                svd_pkg::DIM_X_W'(svd_pkg::MAX_X) : dim_x_reg;
    assign ny = (dim_y_reg == '0) ? svd_pkg::DIM_Y_W'(1) :
                (dim_y_reg > svd_pkg::DIM_Y_W'(svd_pkg::MAX_Y)) ?
                svd_pkg::DIM_Y_W'(svd_pkg::MAX_Y) : dim_y_reg;
    assign nz = (dim_z_reg == '0) ? svd_pkg::DIM_Z_W'(1) :
                (dim_z_reg > svd_pkg::DIM_Z_W'(svd_pkg::MAX_Z)) ?
                svd_pkg::DIM_Z_W'(svd_pkg::MAX_Z) : dim_z_reg;
    assign nx_m1 = nx - svd_pkg::DIM_X_W'(1);
    assign ny_m1 = ny - svd_pkg::DIM_Y_W'(1);
    assign nz_m1 = nz - svd_pkg::DIM_Z_W'(1);

    assign slice_prod = (svd_pkg::DIM_X_W + svd_pkg::DIM_Y_W)'(nx)
                      * (svd_pkg::DIM_X_W + svd_pkg::DIM_Y_W)'(ny);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg    <= svd_pkg::DIM_X_RST;
            dim_y_reg    <= svd_pkg::DIM_Y_RST;
            dim_z_reg    <= svd_pkg::DIM_Z_RST;
            fg_label_reg <= svd_pkg::FG_LABEL_RST;
        end else if (cfg_we) begin
            unique case (svd_pkg::cfg_reg_t'(cfg_index))
                svd_pkg::REG_DIM_X:    dim_x_reg    <= cfg_data[svd_pkg::DIM_X_W-1:0];
                svd_pkg::REG_DIM_Y:    dim_y_reg    <= cfg_data[svd_pkg::DIM_Y_W-1:0];
                svd_pkg::REG_DIM_Z:    dim_z_reg    <= cfg_data[svd_pkg::DIM_Z_W-1:0];
                svd_pkg::REG_FG_LABEL: fg_label_reg <= cfg_data[svd_pkg::LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Plane size register; user must let it move only while idle, not enforced
    always_ff @(posedge aclk) begin
        slice_reg <= slice_prod[svd_pkg::SLICE_W-1:0];
    end

    assign match   = !in_flush && (in_label == fg_label_reg);
    assign has_res = count_reg >= svd_pkg::COUNT_W'(slice_reg);
    assign last    = ({1'b0, out_x_reg} >= nx_m1) && ({1'b0, out_y_reg} >= ny_m1)
                  && ({1'b0, out_z_reg} >= nz_m1);
    assign border  = (out_x_reg == '0) || ({1'b0, out_x_reg} >= nx_m1)
                  || (out_y_reg == '0) || ({1'b0, out_y_reg} >= ny_m1)
                  || (out_z_reg == '0) || ({1'b0, out_z_reg} >= nz_m1);

    // Ring position within one plane; restart at the first item of a volume
    assign p_eff   = (count_reg == '0) ? '0 : ptr_reg;
    assign p_inc   = {1'b0, p_eff} + svd_pkg::SLICE_W'(1);
    assign ptr_next = (p_inc >= slice_reg) ? '0 : p_inc[svd_pkg::ADDR_W-1:0];
    assign up_sum  = {1'b0, p_eff} + svd_pkg::SLICE_W'(nx);
    assign up_wrap = (up_sum >= slice_reg) ? (up_sum - slice_reg) : up_sum;
    assign dn_diff = {1'b0, p_eff} - svd_pkg::SLICE_W'(nx);
    assign dn_wrap = ({1'b0, p_eff} >= svd_pkg::SLICE_W'(nx)) ? dn_diff :
                     (dn_diff + slice_reg);

    assign x_inc = {1'b0, out_x_reg} + svd_pkg::DIM_X_W'(1);
    assign y_inc = {1'b0, out_y_reg} + svd_pkg::DIM_Y_W'(1);
    assign z_inc = {1'b0, out_z_reg} + svd_pkg::DIM_Z_W'(1);

    always_comb begin
        count_next = count_reg + svd_pkg::COUNT_W'(1);
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        out_z_next = out_z_reg;
        if (has_res) begin
            if (last) begin
                count_next = '0;
                out_x_next = '0;
                out_y_next = '0;
                out_z_next = '0;
            end else if (x_inc >= nx) begin
                out_x_next = '0;
                if (y_inc >= ny) begin
                    out_y_next = '0;
                    out_z_next = (z_inc >= nz) ? '0 : z_inc[svd_pkg::POS_Z_W-1:0];
                end else begin
                    out_y_next = y_inc[svd_pkg::POS_Y_W-1:0];
                end
            end else begin
                out_x_next = x_inc[svd_pkg::POS_X_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ptr_reg   <= '0;
            out_x_reg <= '0;
            out_y_reg <= '0;
            out_z_reg <= '0;
        end else if (in_acc) begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
        end
    end

    always_comb begin
        req.valid      = in_acc;
        req.wr_addr    = p_eff;
        req.rd_next    = ptr_next;
        req.rd_up      = up_wrap[svd_pkg::ADDR_W-1:0];
        req.rd_down    = dn_wrap[svd_pkg::ADDR_W-1:0];
        req.match      = match;
        req.has_result = has_res;
        req.border     = border;
        req.one_slice  = (slice_reg == svd_pkg::SLICE_W'(1));
        req.pos_x      = out_x_reg;
        req.pos_y      = out_y_reg;
        req.pos_z      = out_z_reg;
        req.last       = last;
    end

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && has_res && last) |=> (count_reg == '0 && out_x_reg == '0
                                         && out_y_reg == '0 && out_z_reg == '0))
        else $error("volume did not restart after its last voxel");

    a_fill_holds_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !has_res) |=> ($stable(out_x_reg) && $stable(out_y_reg)
                                  && $stable(out_z_reg)))
        else $error("coordinates moved on an item without a result");

endmodule

// ===== rtl/svd_window.sv =====
`timescale 1ns / 1ps

module svd_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  svd_pkg::svd_req_t     req,
    output logic                  res_valid,
    output svd_pkg::svd_result_t  res
);

    // Plane A holds the last plane of input matches, plane B the plane before it
    logic mem_a [svd_pkg::PLANE_DEPTH];
    logic mem_b [svd_pkg::PLANE_DEPTH];

    svd_pkg::svd_req_t s1_reg;
    logic              s1_valid_reg;
    logic              a_next_reg, a_up_reg, b_back_reg, b_down_reg;
    logic              hist1_reg, hist2_reg, prev_m_reg;
    logic              center, surface;

    // Center voxel sits one plane behind the newest item
    assign center = s1_reg.one_slice ? prev_m_reg : hist1_reg;

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            mem_a[req.wr_addr] <= req.match;
            a_next_reg         <= mem_a[req.rd_next];
            a_up_reg           <= mem_a[req.rd_up];
        end
    end

    // Read plane B for the new item, write back the center of the item in stage 1
    always_ff @(posedge aclk) begin
        if (req.valid) begin
            b_back_reg <= mem_b[req.wr_addr];
            b_down_reg <= mem_b[req.rd_down];
        end
        if (s1_valid_reg) begin
            mem_b[s1_reg.wr_addr] <= center;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            s1_reg <= req;
        end
        if (s1_valid_reg) begin
            hist1_reg  <= a_next_reg;
            hist2_reg  <= hist1_reg;
            prev_m_reg <= s1_reg.match;
        end
    end

    // Six face neighbors: left, right, row below/above, plane behind/ahead
    assign surface = center && (s1_reg.border || !hist2_reg || !a_next_reg
                             || !b_down_reg || !a_up_reg || !b_back_reg
                             || !s1_reg.match);

    assign res_valid = s1_valid_reg && s1_reg.has_result;

    always_comb begin
        res.last       = s1_reg.last;
        res.surface    = surface;
        res.foreground = center;
        res.pos_z      = s1_reg.pos_z;
        res.pos_y      = s1_reg.pos_y;
        res.pos_x      = s1_reg.pos_x;
    end

    a_surface_is_fg: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.surface |-> res.foreground)
        else $error("surface flag on a background voxel");

endmodule

// ===== rtl/svd_out_fifo.sv =====
`timescale 1ns / 1ps

module svd_out_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  svd_pkg::svd_result_t                push_data,
    input  logic                                pop,
    output logic                                out_valid,
    output svd_pkg::svd_result_t                out_data,
    output logic [svd_pkg::FIFO_CNT_W-1:0]      level
);

    svd_pkg::svd_result_t               entry_reg [svd_pkg::FIFO_DEPTH];
    logic [svd_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [svd_pkg::FIFO_CNT_W-1:0]     cnt_reg;
    logic                               do_pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign level     = cnt_reg;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == svd_pkg::FIFO_PTR_W'(svd_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + svd_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == svd_pkg::FIFO_PTR_W'(svd_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + svd_pkg::FIFO_PTR_W'(1);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + svd_pkg::FIFO_CNT_W'(1);
            end else if (!push && do_pop) begin
                cnt_reg <= cnt_reg - svd_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < svd_pkg::FIFO_CNT_W'(svd_pkg::FIFO_DEPTH) || do_pop))
        else $error("result pushed into a full queue");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= svd_pkg::FIFO_CNT_W'(svd_pkg::FIFO_DEPTH))
        else $error("queue level beyond its depth");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import svd_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int SETTLE_CYCLES    = 8;      // result path is two stages plus a short queue
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 1400;
    localparam int QUIET_AFTER      = 1000;   // random requests after which all idling stops
    localparam int WIN_DEPTH        = 2 * MAX_X * MAX_Y + 1;

    // Tracks the foreground-match window the way the block sees it and queues up
    // the judgment for every voxel once its look-ahead plane has arrived.
    class voxel_surface_checker;
        logic [DIM_X_W-1:0] dim_x;
        logic [DIM_Y_W-1:0] dim_y;
        logic [DIM_Z_W-1:0] dim_z;
        logic [LABEL_W-1:0] fg_label;
        bit                 match_bits [WIN_DEPTH];
        logic [COUNT_W-1:0] voxel_count;
        int unsigned        next_x;
        int unsigned        next_y;
        int unsigned        next_z;
        svd_result_t        pending_judgments [$];
        int                 mismatches;
        int                 judged;

        function new();
            dim_x       = DIM_X_RST;
            dim_y       = DIM_Y_RST;
            dim_z       = DIM_Z_RST;
            fg_label    = FG_LABEL_RST;
            voxel_count = '0;
            next_x      = 0;
            next_y      = 0;
            next_z      = 0;
            mismatches  = 0;
            judged      = 0;
        endfunction

        static function int unsigned clamp_dim(input int unsigned raw, input int unsigned limit);
            if (raw == 0)
                return 1;
            return (raw > limit) ? limit : raw;
        endfunction

        function void set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_DIM_X:    dim_x    = value[DIM_X_W-1:0];
                REG_DIM_Y:    dim_y    = value[DIM_Y_W-1:0];
                REG_DIM_Z:    dim_z    = value[DIM_Z_W-1:0];
                REG_FG_LABEL: fg_label = value[LABEL_W-1:0];
                default: ;
            endcase
        endfunction

        function bit window_bit(input longint unsigned center, input int back, input int ahead);
            return match_bits[(center + WIN_DEPTH - back + ahead) % WIN_DEPTH];
        endfunction

        function void note_voxel(input logic [LABEL_W-1:0] label, input logic flush);
            int unsigned     nx;
            int unsigned     ny;
            int unsigned     nz;
            int unsigned     plane;
            longint unsigned idx;
            longint unsigned j;
            bit              fg;
            bit              surf;
            bit              at_end;
            svd_result_t     res;
            nx    = clamp_dim(dim_x, MAX_X);
            ny    = clamp_dim(dim_y, MAX_Y);
            nz    = clamp_dim(dim_z, MAX_Z);
            plane = nx * ny;
            idx   = voxel_count;
            match_bits[idx % WIN_DEPTH] = !flush && (label == fg_label);
            voxel_count = voxel_count + 1'b1;
            if (idx < plane)
                return;
            j    = idx - plane;
            fg   = window_bit(j, 0, 0);
            surf = 1'b0;
            if (fg) begin
                if (next_x == 0 || next_x >= nx - 1 || next_y == 0 || next_y >= ny - 1 ||
                    next_z == 0 || next_z >= nz - 1)
                    surf = 1'b1;
                else
                    surf = !window_bit(j, 1, 0) || !window_bit(j, 0, 1) ||
                           !window_bit(j, nx, 0) || !window_bit(j, 0, nx) ||
                           !window_bit(j, plane, 0) || !window_bit(j, 0, plane);
            end
            at_end = next_x >= nx - 1 && next_y >= ny - 1 && next_z >= nz - 1;
            res.pos_x      = POS_X_W'(next_x);
            res.pos_y      = POS_Y_W'(next_y);
            res.pos_z      = POS_Z_W'(next_z);
            res.foreground = fg;
            res.surface    = surf;
            res.last       = at_end;
            pending_judgments.push_back(res);
            if (at_end) begin
                voxel_count = '0;
                next_x      = 0;
                next_y      = 0;
                next_z      = 0;
            end else begin
                next_x++;
                if (next_x >= nx) begin
                    next_x = 0;
                    next_y++;
                    if (next_y >= ny) begin
                        next_y = 0;
                        next_z++;
                        if (next_z >= nz)
                            next_z = 0;
                    end
                end
            end
        endfunction

        function void check_result(input svd_result_t got);
            svd_result_t want;
            judged++;
            if (pending_judgments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no voxel pending: x=%0d y=%0d z=%0d last=%0b",
                             $time, got.pos_x, got.pos_y, got.pos_z, got.last);
                return;
            end
            want = pending_judgments.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.pos_z !== want.pos_z || got.foreground !== want.foreground ||
                got.surface !== want.surface || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] voxel mismatch: expected x=%0d y=%0d z=%0d fg=%0b ",
                              "surf=%0b last=%0b, got x=%0d y=%0d z=%0d fg=%0b surf=%0b last=%0b"},
                             $time, want.pos_x, want.pos_y, want.pos_z, want.foreground,
                             want.surface, want.last, got.pos_x, got.pos_y, got.pos_z,
                             got.foreground, got.surface, got.last);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    voxel_surface_checker judge_sb = new();

    int          cycle_count = 0;
    int          src_gap_pct;      // chance per request of a sender gap burst
    int          sink_stall_pct;   // chance per cycle of a receiver stall burst
    bit          hold_sink;        // ask the receiver for one long hold-off
    int unsigned offered;          // requests accepted by the block
    int          volumes;
    svd_result_t seen;

    surface_voxel_detector_3d dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Abort a hung run: every correct run finishes well inside this limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sample each accepted result at the rising edge and hand it to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{last: m_tlast, surface: m_tuser[1], foreground: m_tuser[0],
                     pos_z: m_tdata[27:16], pos_y: m_tdata[15:8], pos_x: m_tdata[7:0]};
            judge_sb.check_result(seen);
        end
    end

    // Receiver: drop tready in random bursts, or hold it low for one long stretch
    // when asked so the result queue fills and the block stalls its input.
    initial begin : sink_drive
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                hold_sink = 1'b0;
            end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Write one register; only call while no request is in flight.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        judge_sb.set_reg(idx, value);
    endtask

    // Offer one voxel request, maybe after a gap burst, and hold it until accepted.
    task automatic offer_voxel(input logic [LABEL_W-1:0] label, input logic flush);
        int gap;
        @(negedge aclk);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= label;
        s_tuser[0] <= flush;
        do @(posedge aclk); while (!s_tready);
        judge_sb.note_voxel(label, flush);
        offered++;
    endtask

    // Stop offering, wait for every pending judgment, then let the pipe settle.
    task automatic wait_for_results(input int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (judge_sb.pending_judgments.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Random dimension, sometimes zero, sometimes with junk above the register width.
    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int unsigned top,
                                                        input int unsigned width);
        logic [CFG_DATA_W-1:0] v;
        v = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, top));
        if ($urandom_range(0, 3) == 0)
            v = v | (CFG_DATA_W'($urandom) << width);
        return v;
    endfunction

    // Configure one volume, stream its voxels, then one plane of trailing requests
    // that drains the window and ends with the last judgment.
    task automatic run_volume(input logic [CFG_DATA_W-1:0] raw_x, input logic [CFG_DATA_W-1:0] raw_y,
                              input logic [CFG_DATA_W-1:0] raw_z, input logic [LABEL_W-1:0] label,
                              input int fg_pct, input int flush_pct, input bit stress);
        int unsigned plane;
        int unsigned body;
        int unsigned n;
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_DIM_X, raw_x);
        write_reg(REG_DIM_Y, raw_y);
        write_reg(REG_DIM_Z, raw_z);
        write_reg(REG_FG_LABEL, label);
        plane = voxel_surface_checker::clamp_dim(raw_x[DIM_X_W-1:0], MAX_X) *
                voxel_surface_checker::clamp_dim(raw_y[DIM_Y_W-1:0], MAX_Y);
        body  = plane * voxel_surface_checker::clamp_dim(raw_z[DIM_Z_W-1:0], MAX_Z);
        if (stress)
            hold_sink = 1'b1;
        for (n = 0; n < body + plane; n++) begin
            // halfway through, pause the sender until the block has caught up
            if (stress && n == body / 2)
                wait_for_results(0);
            if (n < body) begin
                if ($urandom_range(0, 99) < flush_pct)
                    offer_voxel(LABEL_W'($urandom), 1'b1);
                else if ($urandom_range(0, 99) < fg_pct)
                    offer_voxel(label, 1'b0);
                else
                    offer_voxel(LABEL_W'($urandom), 1'b0);
            end else begin
                // trailing requests: mostly flush, some plain voxels
                offer_voxel(LABEL_W'($urandom), $urandom_range(0, 99) < 85);
            end
        end
        volumes++;
    endtask

    initial begin : stimulus
        int unsigned random_start;
        int          fg_pct;
        bit          quiet;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DIM_X;
        cfg_data       = '0;
        aresetn        = 1'b0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_sink      = 1'b0;
        offered        = 0;
        volumes        = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single-voxel volumes: zero dimensions act as one, label keeps its reset value.
        write_reg(REG_DIM_X, '0);
        write_reg(REG_DIM_Y, '0);
        write_reg(REG_DIM_Z, '0);
        offer_voxel(16'h0001, 1'b0);   // foreground, so on every face
        offer_voxel(16'hA5A5, 1'b1);
        offer_voxel(16'h0000, 1'b0);   // background voxel
        offer_voxel(16'h0001, 1'b1);   // flush ignores a matching label
        offer_voxel(16'h0001, 1'b1);   // flush inside the volume reads as background
        offer_voxel(16'hFFFF, 1'b0);   // plain voxel in the trailing plane
        volumes += 3;

        // Solid 3x3x3 block: only the center voxel is interior and not on the surface.
        run_volume(16'd3, 16'd3, 16'd3, 16'hFFFF, 100, 0, 1'b0);

        // Extreme dimensions: width written far past the limit, full height, full depth.
        src_gap_pct    = 8;
        sink_stall_pct = 8;
        run_volume(16'hFFFF, 16'd1, 16'd1, 16'h0000, 90, 3, 1'b0);
        run_volume(16'd1, 16'd256, 16'd1, 16'h8000, 90, 3, 1'b0);
        run_volume(16'd1, 16'd1, 16'd4096, 16'h7FFF, 90, 3, 1'b1);

        // Random small volumes; the tail of the run goes at full rate on both sides.
        random_start = offered;
        while (offered - random_start < RANDOM_ITEMS) begin
            quiet = (offered - random_start) >= QUIET_AFTER;
            case ($urandom_range(0, 2))
                0: src_gap_pct = 0;
                1: src_gap_pct = 6;
                default: src_gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 6;
                default: sink_stall_pct = 30;
            endcase
            if (quiet) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            case ($urandom_range(0, 3))
                0: fg_pct = 50;
                1: fg_pct = 85;
                2: fg_pct = 97;
                default: fg_pct = 100;
            endcase
            run_volume(pick_dim(5, DIM_X_W), pick_dim(5, DIM_Y_W), pick_dim(6, DIM_Z_W),
                       LABEL_W'($urandom), fg_pct, 4, 1'b0);
        end

        // Drain, then give any stray result time to show up.
        wait_for_results(SETTLE_CYCLES);
        $display("Streamed %0d voxel requests over %0d volumes and judged %0d voxels, %0d wrong",
                 offered, volumes, judge_sb.judged, judge_sb.mismatches);
        $display("Sizes ran from one voxel up to 256 wide, 256 tall and 4096 deep, under stalls");
        if (judge_sb.mismatches == 0 && judge_sb.pending_judgments.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/svd_pkg.sv
rtl/svd_ctrl.sv
rtl/svd_window.sv
rtl/svd_out_fifo.sv
rtl/surface_voxel_detector_3d.sv
test/tb.sv
